FILE: src/msm_pkg.sv
// msm_pkg: shared constants, operation codes and types of the matrix store multiply block
package msm_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int IDX_W         = 2;
    localparam int CFG_W         = 3;
    localparam int CFG_IDX_W     = 1;

    localparam int MAX_DIM_DEF   = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_RESET_DEF = 4;

    localparam logic [OP_W-1:0] OP_WRITE_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_A   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'd1;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

endpackage

FILE: src/msm_store.sv
// msm_store: element memory with registered read and per-entry reset pattern
module msm_store #(
    parameter int MAX_DIM     = msm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS   = msm_pkg::FRAC_BITS_DEF,
    parameter bit IDENT_RESET = 1'b0
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       wr_en,
    input  logic [2*$clog2(MAX_DIM)-1:0]               wr_addr,
    input  logic signed [msm_pkg::DATA_W-1:0]          wr_data,
    input  logic                                       rd_en,
    input  logic [2*$clog2(MAX_DIM)-1:0]               rd_addr,
    output logic signed [msm_pkg::DATA_W-1:0]          rd_data
);
    import msm_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * DIM_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]         valid_reg;
    logic                     rd_valid_reg;
    logic                     rd_diag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_diag_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_diag_reg  <= (rd_addr[ADDR_W-1:DIM_W] == rd_addr[DIM_W-1:0]);
            end
        end
    end

    // unwritten entries read as their reset pattern
    assign rd_data = rd_valid_reg ? rd_data_reg
                   : ((IDENT_RESET && rd_diag_reg) ? ONE : '0);

endmodule

FILE: src/msm_mac.sv
// msm_mac: pipelined multiply accumulate with floor truncation and saturation
module msm_mac #(
    parameter int MAX_DIM   = msm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = msm_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msm_pkg::mac_ctrl_t                ctrl,
    input  logic signed [msm_pkg::DATA_W-1:0] a_op,
    input  logic signed [msm_pkg::DATA_W-1:0] b_op,
    output logic                              res_valid,
    output logic signed [msm_pkg::DATA_W-1:0] res_data
);
    import msm_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + DIM_W;
    localparam int SH_W   = ACC_W - FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctrl_t                ctl1_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     res_valid_reg;
    logic signed [SH_W-1:0]   quot;
    logic                     ovf;
    logic signed [DATA_W-1:0] sat;

    always_comb
    begin
        acc_next = ctl1_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        quot     = acc_reg[ACC_W-1:FRAC_BITS];
        ovf      = !((&quot[SH_W-1:DATA_W-1]) || (~|quot[SH_W-1:DATA_W-1]));
        sat      = ovf ? (quot[SH_W-1] ? DATA_MIN : DATA_MAX) : quot[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_op * b_op;
        if (ctl1_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (done_reg)
        begin
            res_reg <= sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg      <= '0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg      <= ctrl;
            done_reg      <= ctl1_reg.valid && ctl1_reg.last;
            res_valid_reg <= done_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

FILE: src/matrix_store_multiply.sv
// matrix_store_multiply: matrix store with element access and in-place multiply by a square operand
//
//  channel   signals                                        transfer when
//  -------   --------------------------------------------   --------------------------
//  config    cfg_wr_en cfg_index cfg_data                   cfg_wr_en
//  input     in_valid in_stall op row_index col_index        in_valid && !in_stall
//            elem_value
//  output    out_valid out_stall read_value                 out_valid && !out_stall
//
//  a multiply is paced by the single read port of each memory and by the
//  multiply accumulate latency per element
//  a finished result waits in the output register while the next transfer is taken
//  reset: A reads as identity, B as zero, both dimensions at their default
module matrix_store_multiply #(
    parameter int MAX_DIM   = msm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = msm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [msm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [msm_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [msm_pkg::OP_W-1:0]             op,
    input  logic [msm_pkg::IDX_W-1:0]            row_index,
    input  logic [msm_pkg::IDX_W-1:0]            col_index,
    input  logic signed [msm_pkg::DATA_W-1:0]    elem_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [msm_pkg::DATA_W-1:0]    read_value
);
    import msm_pkg::*;

    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int CMP_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int DIM_RST = (MAX_DIM < DIM_RESET_DEF) ? MAX_DIM : DIM_RESET_DEF;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_COPY = 3'd2;
    localparam logic [2:0] S_MAC  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0)
        begin
            res = CFG_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            res = CFG_W'(MAX_DIM);
        end
        return res;
    endfunction

    logic [2:0]               state_reg, state_next;
    logic [DIM_W-1:0]         r_reg, r_next;
    logic [DIM_W-1:0]         c_reg, c_next;
    logic [DIM_W-1:0]         k_reg, k_next;
    logic [DIM_W-1:0]         kd_reg;
    logic                     copy_vld_reg, copy_vld_next;
    mac_ctrl_t                mac_ctl_reg, mac_ctl_next;
    logic                     rd_ok_reg, rd_ok_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    logic [CFG_W-1:0]         num_rows_reg;
    logic [CFG_W-1:0]         num_cols_reg;
    logic signed [DATA_W-1:0] rowbuf_reg [MAX_DIM];

    logic                     in_acc;
    logic                     slot_free;
    logic                     a_in_rng;
    logic                     b_in_rng;
    logic [ADDR_W-1:0]        acc_addr;
    logic                     k_last, c_last, r_last;

    logic                     a_wr_en, a_rd_en;
    logic [ADDR_W-1:0]        a_wr_addr, a_rd_addr;
    logic signed [DATA_W-1:0] a_wr_data, a_rd_data;
    logic                     b_wr_en, b_rd_en;
    logic [ADDR_W-1:0]        b_rd_addr;
    logic signed [DATA_W-1:0] b_rd_data;
    logic                     mac_res_valid;
    logic signed [DATA_W-1:0] mac_res_data;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign a_in_rng = (CFG_W'(row_index) < num_rows_reg) && (CFG_W'(col_index) < num_cols_reg);
    assign b_in_rng = (CFG_W'(row_index) < num_cols_reg) && (CFG_W'(col_index) < num_cols_reg);
    assign acc_addr = {DIM_W'(row_index), DIM_W'(col_index)};

    assign k_last = (CMP_W'(k_reg) == CMP_W'(num_cols_reg - CFG_W'(1)));
    assign c_last = (CMP_W'(c_reg) == CMP_W'(num_cols_reg - CFG_W'(1)));
    assign r_last = (CMP_W'(r_reg) == CMP_W'(num_rows_reg - CFG_W'(1)));

    // matrix A ports: element access or multiply traffic
    assign a_wr_en   = (in_acc && (op == OP_WRITE_A) && a_in_rng)
                    || ((state_reg == S_WAIT) && mac_res_valid);
    assign a_wr_addr = (state_reg == S_WAIT) ? {r_reg, c_reg} : acc_addr;
    assign a_wr_data = (state_reg == S_WAIT) ? mac_res_data : elem_value;
    assign a_rd_en   = (in_acc && (op == OP_READ_A)) || (state_reg == S_COPY);
    assign a_rd_addr = (state_reg == S_COPY) ? {r_reg, k_reg} : acc_addr;

    assign b_wr_en   = in_acc && (op == OP_WRITE_B) && b_in_rng;
    assign b_rd_en   = (state_reg == S_MAC);
    assign b_rd_addr = {k_reg, c_reg};

    msm_store #(
        .MAX_DIM     (MAX_DIM),
        .FRAC_BITS   (FRAC_BITS),
        .IDENT_RESET (1'b1)
    ) u_a_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (a_wr_en),
        .wr_addr (a_wr_addr),
        .wr_data (a_wr_data),
        .rd_en   (a_rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    msm_store #(
        .MAX_DIM     (MAX_DIM),
        .FRAC_BITS   (FRAC_BITS),
        .IDENT_RESET (1'b0)
    ) u_b_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_wr_en),
        .wr_addr (acc_addr),
        .wr_data (elem_value),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    msm_mac #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctl_reg),
        .a_op      (rowbuf_reg[kd_reg]),
        .b_op      (b_rd_data),
        .res_valid (mac_res_valid),
        .res_data  (mac_res_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        copy_vld_next  = 1'b0;
        mac_ctl_next   = '0;
        rd_ok_next     = rd_ok_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (op)
                        OP_READ_A:
                        begin
                            rd_ok_next = a_in_rng;
                            state_next = S_READ;
                        end
                        OP_MULTIPLY:
                        begin
                            r_next     = '0;
                            c_next     = '0;
                            k_next     = '0;
                            state_next = S_COPY;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next   = rd_ok_reg ? a_rd_data : '0;
                state_next = S_DONE;
            end
            S_COPY:
            begin
                // snapshot the row before it is overwritten
                copy_vld_next = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    c_next     = '0;
                    state_next = S_MAC;
                end
                else
                begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            S_MAC:
            begin
                mac_ctl_next.valid = 1'b1;
                mac_ctl_next.first = (k_reg == '0);
                mac_ctl_next.last  = k_last;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = S_WAIT;
                end
                else
                begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            S_WAIT:
            begin
                if (mac_res_valid)
                begin
                    if (c_last)
                    begin
                        c_next = '0;
                        if (r_last)
                        begin
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            r_next     = r_reg + DIM_W'(1);
                            state_next = S_COPY;
                        end
                    end
                    else
                    begin
                        c_next     = c_reg + DIM_W'(1);
                        state_next = S_MAC;
                    end
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            copy_vld_reg  <= 1'b0;
            mac_ctl_reg   <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            num_rows_reg  <= CFG_W'(DIM_RST);
            num_cols_reg  <= CFG_W'(DIM_RST);
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            copy_vld_reg  <= copy_vld_next;
            mac_ctl_reg   <= mac_ctl_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en && (cfg_index == CFG_NUM_ROWS))
            begin
                num_rows_reg <= clamp_dim(cfg_data);
            end
            if (cfg_wr_en && (cfg_index == CFG_NUM_COLS))
            begin
                num_cols_reg <= clamp_dim(cfg_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kd_reg       <= k_reg;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        if (copy_vld_reg)
        begin
            rowbuf_reg[kd_reg] <= a_rd_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_data_reg;

    // multiply results only come back while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_res_valid |-> (state_reg == S_WAIT))
        else $error("mac result outside of wait state");

    // walk counters stay inside the active dimensions
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_COPY) || (state_reg == S_MAC)) |->
            ((CMP_W'(k_reg) < CMP_W'(num_cols_reg)) && (CMP_W'(r_reg) < CMP_W'(num_rows_reg))
             && (CMP_W'(c_reg) < CMP_W'(num_cols_reg))))
        else $error("walk counter beyond dimension");

    // a finished result is held until the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !slot_free) |=> ((state_reg == S_DONE) && $stable(res_reg)))
        else $error("pending result lost");

    // a completed result always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && slot_free) |=> (out_valid_reg && (out_data_reg == $past(res_reg))))
        else $error("result not transferred to output register");

endmodule

FILE: tb/matrix_store_multiply_tb.sv
// matrix_store_multiply_tb: self-checking testbench for the matrix store multiply block
`timescale 1ns / 100ps

module matrix_store_multiply_tb;
    import msm_pkg::*;

    localparam int DIM         = MAX_DIM_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int ONE_Q       = 1 << FRAC;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 200;

    logic                     clk;
    logic                     rst_n      = 1'b0;
    logic                     cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index  = '0;
    logic [CFG_W-1:0]         cfg_data   = '0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          op         = '0;
    logic [IDX_W-1:0]         row_index  = '0;
    logic [IDX_W-1:0]         col_index  = '0;
    logic signed [DATA_W-1:0] elem_value = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [DATA_W-1:0] read_value;

    logic signed [DATA_W-1:0] a_mirror [DIM][DIM];
    logic signed [DATA_W-1:0] b_mirror [DIM][DIM];
    int unsigned              rows_in_use;
    int unsigned              cols_in_use;
    logic [DATA_W-1:0]        pending_reads [$];
    logic [DATA_W-1:0]        wanted_read;

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int multiplies_done = 0;
    int cycle_count     = 0;
    bit hold_request    = 1'b0;
    bit no_idle         = 1'b0;

    matrix_store_multiply dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .row_index  (row_index),
        .col_index  (col_index),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > DIM)
            return DIM;
        return int'(value);
    endfunction

    // A <= A * B, row by row through a saved copy of the row
    function automatic void multiply_a_by_b();
        logic signed [DATA_W-1:0]   row_copy [DIM];
        logic signed [2*DATA_W+7:0] acc;
        int unsigned                r;
        int unsigned                c;
        int unsigned                k;
        for (r = 0; r < rows_in_use; r++)
        begin
            for (k = 0; k < cols_in_use; k++)
                row_copy[k] = a_mirror[r][k];
            for (c = 0; c < cols_in_use; c++)
            begin
                acc = '0;
                for (k = 0; k < cols_in_use; k++)
                    acc = acc + row_copy[k] * b_mirror[k][c];
                acc = acc >>> FRAC;
                if (acc > DATA_MAX)
                    a_mirror[r][c] = DATA_MAX;
                else if (acc < DATA_MIN)
                    a_mirror[r][c] = DATA_MIN;
                else
                    a_mirror[r][c] = acc[DATA_W-1:0];
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] predict_item(logic [OP_W-1:0] code,
                                                       logic [IDX_W-1:0] r,
                                                       logic [IDX_W-1:0] c,
                                                       logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] found;
        found = '0;
        case (code)
            OP_WRITE_A:
                if (r < rows_in_use && c < cols_in_use)
                    a_mirror[r][c] = value;
            OP_WRITE_B:
                if (r < cols_in_use && c < cols_in_use)
                    b_mirror[r][c] = value;
            OP_MULTIPLY:
                multiply_a_by_b();
            OP_READ_A:
                if (r < rows_in_use && c < cols_in_use)
                    found = a_mirror[r][c];
            default:
                found = '0;
        endcase
        return found;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: v = DATA_MAX;
                    1: v = DATA_MIN;
                    2: v = '0;
                    3: v = '1;
                    4: v = 32'd1;
                    default: v = ONE_Q;
                endcase
            end
            3, 4: v = 32'(($urandom_range(0, 15) - 8) << FRAC);
            default: v = 32'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        endcase
        return v;
    endfunction

    task automatic send_item(logic [OP_W-1:0] code, logic [IDX_W-1:0] r,
                             logic [IDX_W-1:0] c, logic [DATA_W-1:0] value);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        row_index  <= r;
        col_index  <= c;
        elem_value <= value;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_reads.push_back(predict_item(code, r, c, value));
        items_sent++;
        if (code == OP_MULTIPLY)
            multiplies_done++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reads.size() != 0);
    endtask

    task automatic set_dim(logic [CFG_IDX_W-1:0] which, logic [CFG_W-1:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (which == CFG_NUM_ROWS)
            rows_in_use = clamp_dim(value);
        else
            cols_in_use = clamp_dim(value);
    endtask

    task automatic send_random_item();
        send_item(OP_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
                  IDX_W'($urandom_range(0, 3)), pick_value());
    endtask

    // load B, load A, multiply, read back
    task automatic run_matrix_sequence();
        int n;
        int k;
        n = $urandom_range(1, cols_in_use * cols_in_use);
        for (k = 0; k < n; k++)
            send_item(OP_WRITE_B, IDX_W'($urandom_range(0, cols_in_use - 1)),
                      IDX_W'($urandom_range(0, cols_in_use - 1)), pick_value());
        n = $urandom_range(1, rows_in_use * cols_in_use);
        for (k = 0; k < n; k++)
            send_item(OP_WRITE_A, IDX_W'($urandom_range(0, rows_in_use - 1)),
                      IDX_W'($urandom_range(0, cols_in_use - 1)), pick_value());
        n = $urandom_range(1, 2);
        for (k = 0; k < n; k++)
            send_item(OP_MULTIPLY, IDX_W'($urandom_range(0, 3)),
                      IDX_W'($urandom_range(0, 3)), pick_value());
        n = $urandom_range(1, rows_in_use * cols_in_use);
        for (k = 0; k < n; k++)
            send_item(OP_READ_A, IDX_W'($urandom_range(0, rows_in_use - 1)),
                      IDX_W'($urandom_range(0, cols_in_use - 1)), pick_value());
        if ($urandom_range(0, 7) == 0)
            drain_results();
    endtask

    task automatic run_random_phase(logic [CFG_W-1:0] rows_raw, logic [CFG_W-1:0] cols_raw,
                                    int count);
        int stop_at;
        set_dim(CFG_NUM_ROWS, rows_raw);
        set_dim(CFG_NUM_COLS, cols_raw);
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 6)) send_random_item();
            else
                run_matrix_sequence();
        end
    endtask

    task automatic test_reset_state();
        send_item(OP_READ_A, 2'd0, 2'd0, '0);
        send_item(OP_READ_A, 2'd3, 2'd3, '0);
        send_item(OP_READ_A, 2'd1, 2'd2, '0);
    endtask

    // identity times B gives B back
    task automatic test_identity_multiply();
        send_item(OP_WRITE_B, 2'd0, 2'd0, DATA_MAX);
        send_item(OP_WRITE_B, 2'd3, 2'd3, DATA_MIN);
        send_item(OP_WRITE_B, 2'd1, 2'd2, '1);
        send_item(OP_MULTIPLY, 2'd0, 2'd0, '0);
        send_item(OP_READ_A, 2'd0, 2'd0, '0);
        send_item(OP_READ_A, 2'd3, 2'd3, '0);
        send_item(OP_READ_A, 2'd1, 2'd2, '0);
    endtask

    // saturation both ways and truncation of a negative fraction
    task automatic test_saturation_and_truncation();
        send_item(OP_WRITE_A, 2'd0, 2'd0, DATA_MAX);
        send_item(OP_WRITE_A, 2'd1, 2'd0, DATA_MIN);
        send_item(OP_WRITE_A, 2'd2, 2'd0, '1);
        send_item(OP_WRITE_B, 2'd0, 2'd1, 32'd1);
        send_item(OP_MULTIPLY, 2'd3, 2'd3, '1);
        send_item(OP_READ_A, 2'd0, 2'd0, '0);
        send_item(OP_READ_A, 2'd1, 2'd0, '0);
        send_item(OP_READ_A, 2'd2, 2'd1, '0);
        send_item(OP_READ_A, 2'd1, 2'd1, '0);
    endtask

    // clamped dimension writes, ignored accesses, contents kept across changes
    task automatic test_out_of_range();
        set_dim(CFG_NUM_ROWS, 3'd0);
        set_dim(CFG_NUM_COLS, 3'd7);
        send_item(OP_WRITE_A, 2'd2, 2'd0, 32'h1234_5678);
        send_item(OP_READ_A, 2'd2, 2'd0, '0);
        send_item(OP_READ_A, 2'd0, 2'd3, '0);
        set_dim(CFG_NUM_COLS, 3'd0);
        send_item(OP_WRITE_B, 2'd1, 2'd0, 32'h7654_3210);
        send_item(OP_WRITE_B, 2'd0, 2'd1, 32'h0bad_f00d);
        send_item(OP_READ_A, 2'd0, 2'd1, '0);
        send_item(OP_MULTIPLY, 2'd0, 2'd0, '0);
        set_dim(CFG_NUM_ROWS, 3'd4);
        set_dim(CFG_NUM_COLS, 3'd4);
        send_item(OP_READ_A, 2'd2, 2'd1, '0);
        send_item(OP_READ_A, 2'd0, 2'd0, '0);
    endtask

    task automatic test_random_traffic();
        run_random_phase(3'd4, 3'd4, 220);
        run_random_phase(3'd0, 3'd0, 160);
        run_random_phase(3'd1, 3'd7, 200);
        run_random_phase(3'd6, 3'd1, 200);
        run_random_phase(3'd2, 3'd3, 220);
        run_random_phase(3'd3, 3'd2, 220);
        run_random_phase(3'd5, 3'd4, 220);
    endtask

    // output held off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (40) send_random_item();
        drain_results();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_random_phase(3'd4, 3'd4, 250);
    endtask

    initial
    begin : receiver
        int span;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                for (span = 0; span < HOLD_CYCLES; span++)
                    @(posedge clk);
                out_stall    <= 1'b0;
                hold_request = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_reads.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual read_value %h",
                         $time, read_value);
            end
            else
            begin
                wanted_read = pending_reads.pop_front();
                results_checked++;
                if (read_value !== wanted_read)
                begin
                    error_count++;
                    $display("%0t: read_value mismatch, expected %h, actual %h",
                             $time, wanted_read, read_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_reads.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : main
        int i;
        int j;
        for (i = 0; i < DIM; i++)
        begin
            for (j = 0; j < DIM; j++)
            begin
                a_mirror[i][j] = (i == j) ? ONE_Q : 0;
                b_mirror[i][j] = '0;
            end
        end
        rows_in_use = DIM_RESET_DEF;
        cols_in_use = DIM_RESET_DEF;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_identity_multiply();
        test_saturation_and_truncation();
        test_out_of_range();
        test_random_traffic();
        test_output_backpressure();
        test_back_to_back();

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (pending_reads.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_reads.size());
        end
        $display("covered %0d transfers in (%0d multiplies), %0d results compared, %0d errors",
                 items_sent, multiplies_done, results_checked, error_count);
        $display("dims 1x1 to 4x4 with clamped settings, long output hold, back-to-back traffic");
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/msm_pkg.sv
src/msm_store.sv
src/msm_mac.sv
src/matrix_store_multiply.sv
tb/matrix_store_multiply_tb.sv
